// ----- hdl/lpmp_pkg.sv -----
// Shared types and constants for the length-prefixed message parser.
package lpmp_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned SECTION_W  = 4;
	localparam int unsigned HDR_NUM_W  = 16;
	localparam int unsigned ERR_W      = 3;
	localparam int unsigned REM_W      = 32;
	localparam int unsigned POS_W      = 2;
	localparam int unsigned TFN_W      = 2;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 3;

	// register word index, taken from paddr above the byte offset
	localparam logic REG_FRAME_MODE = 1'b0;

	localparam logic [BYTE_W-1:0] MARK_REQUEST  = 8'h01;
	localparam logic [BYTE_W-1:0] MARK_RESPONSE = 8'h02;

	localparam logic FRAME_MODE_RESET = 1'b0;

	typedef enum logic [3:0] {
		PH_MARKER = 4'd0,
		PH_TLEN   = 4'd1,
		PH_TTEXT  = 4'd2,
		PH_STATUS = 4'd3,
		PH_HCOUNT = 4'd4,
		PH_HLEN   = 4'd5,
		PH_HTEXT  = 4'd6,
		PH_BSIZE  = 4'd7,
		PH_BODY   = 4'd8
	} phase_t;

	typedef logic [SECTION_W-1:0] section_t;
	localparam section_t SEC_MARKER  = 4'd0;
	localparam section_t SEC_TEXT1   = 4'd1;
	localparam section_t SEC_STATUS  = 4'd5;
	localparam section_t SEC_HCOUNT  = 4'd6;
	localparam section_t SEC_NAME    = 4'd7;
	localparam section_t SEC_VALUE   = 4'd8;
	localparam section_t SEC_BSIZE   = 4'd9;
	localparam section_t SEC_BODY    = 4'd10;
	localparam section_t SEC_DISCARD = 4'd11;

	typedef logic [ERR_W-1:0] err_t;
	localparam err_t ERR_NONE    = 3'd0;
	localparam err_t ERR_MARKER  = 3'd1;
	localparam err_t ERR_LEADING = 3'd2;
	localparam err_t ERR_HCOUNT  = 3'd3;
	localparam err_t ERR_HEADER  = 3'd4;
	localparam err_t ERR_BSIZE   = 3'd5;
	localparam err_t ERR_BODY    = 3'd6;

endpackage

// ----- hdl/lpmp_in_if.sv -----
// Input byte channel: valid/ready with byte and last flag.
interface lpmp_in_if;
	logic                        valid;
	logic                        ready;
	logic [lpmp_pkg::BYTE_W-1:0] in_byte;
	logic                        last_byte;

	modport source (output valid, output in_byte, output last_byte, input ready);
	modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// ----- hdl/lpmp_out_if.sv -----
// Result channel: valid/ready with passed-through byte and its tags.
interface lpmp_out_if;
	logic                           valid;
	logic                           ready;
	logic [lpmp_pkg::BYTE_W-1:0]    out_byte;
	lpmp_pkg::section_t             section;
	logic                           is_length_byte;
	logic [lpmp_pkg::HDR_NUM_W-1:0] header_number;
	logic                           message_done;
	lpmp_pkg::err_t                 error_kind;

	modport source (output valid, output out_byte, output section, output is_length_byte,
		output header_number, output message_done, output error_kind, input ready);
	modport sink   (input valid, input out_byte, input section, input is_length_byte,
		input header_number, input message_done, input error_kind, output ready);
endinterface

// ----- hdl/length_prefixed_message_parser_top.sv -----
// Length-prefixed message parser: framing check and per-byte tagging.
//
//  channel   dir  handshake        payload
//  byte_ch   in   valid/ready      in_byte, last_byte
//  tag_ch    out  valid/ready      out_byte, section, is_length_byte, header_number,
//                                  message_done, error_kind
//  apb       in   psel/penable     frame_mode at byte address 0
//
//  One byte per cycle while the output is not stalled; each result appears in the cycle after its request is taken.
//  The parse state and the result register both update at the accepting edge.
//  byte_ch.ready stays high while the result register is empty or being drained,
//  so a stalled output holds one result and stops input only then.
//  arst_n clears the parse state, the result valid and frame_mode.
module length_prefixed_message_parser_top (
	input  logic                                clk,
	input  logic                                arst_n,
	lpmp_in_if.sink                             byte_ch,
	lpmp_out_if.source                          tag_ch,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [lpmp_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [lpmp_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [lpmp_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);

	logic frame_mode_q;

	lpmp_pkg::phase_t                 phase_q, nxt_phase;
	logic [lpmp_pkg::POS_W-1:0]       pos_q, nxt_pos, pos_inc;
	logic [lpmp_pkg::REM_W-1:0]       rem_q, nxt_rem, rem_shift, rem_dec;
	logic [lpmp_pkg::TFN_W-1:0]       tfn_q, nxt_tfn;
	logic [lpmp_pkg::HDR_NUM_W-1:0]   left_q, nxt_left, left_dec;
	logic [lpmp_pkg::HDR_NUM_W-1:0]   cnt_q, nxt_cnt;
	logic                             inval_q, nxt_inval;
	lpmp_pkg::err_t                   err_q, nxt_err;

	lpmp_pkg::section_t               sec;
	logic                             len_byte;
	logic [lpmp_pkg::HDR_NUM_W-1:0]   hnum;
	lpmp_pkg::err_t                   code;

	logic                             in_acc;
	logic                             cfg_wr;

	logic                             out_valid_q;
	logic [lpmp_pkg::BYTE_W-1:0]      out_byte_q;
	lpmp_pkg::section_t               section_q;
	logic                             len_q;
	logic [lpmp_pkg::HDR_NUM_W-1:0]   hnum_q;
	logic                             done_q;
	lpmp_pkg::err_t                   code_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[lpmp_pkg::APB_ADDR_W-1] == lpmp_pkg::REG_FRAME_MODE);
	assign prdata = (paddr[lpmp_pkg::APB_ADDR_W-1] == lpmp_pkg::REG_FRAME_MODE)
		? {{(lpmp_pkg::APB_DATA_W-1){1'b0}}, frame_mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_mode_q <= lpmp_pkg::FRAME_MODE_RESET;
		end else if (cfg_wr) begin
			frame_mode_q <= pwdata[0];
		end
	end

	assign byte_ch.ready = !out_valid_q || tag_ch.ready;
	assign in_acc = byte_ch.valid && byte_ch.ready;

	// big-endian prefix shift: first byte loads, later bytes shift in
	assign rem_shift = (pos_q == '0) ? {{(lpmp_pkg::REM_W-lpmp_pkg::BYTE_W){1'b0}}, byte_ch.in_byte}
		: {rem_q[lpmp_pkg::REM_W-lpmp_pkg::BYTE_W-1:0], byte_ch.in_byte};
	assign pos_inc  = pos_q + 1'b1;
	assign rem_dec  = rem_q - 1'b1;
	assign left_dec = left_q - 1'b1;

	always_comb begin
		nxt_phase = phase_q;
		nxt_pos   = pos_q;
		nxt_rem   = rem_q;
		nxt_tfn   = tfn_q;
		nxt_left  = left_q;
		nxt_cnt   = cnt_q;
		nxt_inval = inval_q;
		nxt_err   = err_q;
		sec       = lpmp_pkg::SEC_DISCARD;
		len_byte  = 1'b0;
		hnum      = '0;
		code      = lpmp_pkg::ERR_NONE;

		if (err_q == lpmp_pkg::ERR_NONE) begin
			case (phase_q)
				lpmp_pkg::PH_TLEN: begin
					sec      = lpmp_pkg::SEC_TEXT1 + lpmp_pkg::section_t'(tfn_q);
					len_byte = 1'b1;
					nxt_rem  = rem_shift;
					nxt_pos  = pos_inc;
					if (pos_inc == 2'd2) begin
						nxt_pos = '0;
						if (rem_shift == '0) begin
							if (tfn_q == 2'd3) begin
								nxt_tfn   = '0;
								nxt_phase = lpmp_pkg::PH_HCOUNT;
							end else begin
								nxt_tfn   = tfn_q + 1'b1;
								nxt_phase = lpmp_pkg::PH_TLEN;
							end
						end else begin
							nxt_phase = lpmp_pkg::PH_TTEXT;
						end
					end
				end
				lpmp_pkg::PH_TTEXT: begin
					sec     = lpmp_pkg::SEC_TEXT1 + lpmp_pkg::section_t'(tfn_q);
					nxt_rem = rem_dec;
					if (rem_dec == '0) begin
						if (tfn_q == 2'd3) begin
							nxt_tfn   = '0;
							nxt_phase = lpmp_pkg::PH_HCOUNT;
						end else begin
							nxt_tfn   = tfn_q + 1'b1;
							nxt_phase = lpmp_pkg::PH_TLEN;
						end
					end
				end
				lpmp_pkg::PH_STATUS: begin
					sec     = lpmp_pkg::SEC_STATUS;
					nxt_rem = rem_shift;
					nxt_pos = pos_inc;
					if (pos_inc == 2'd2) begin
						nxt_pos   = '0;
						nxt_phase = lpmp_pkg::PH_HCOUNT;
					end
				end
				lpmp_pkg::PH_HCOUNT: begin
					sec      = lpmp_pkg::SEC_HCOUNT;
					len_byte = 1'b1;
					nxt_rem  = rem_shift;
					nxt_pos  = pos_inc;
					if (pos_inc == 2'd2) begin
						nxt_pos   = '0;
						nxt_left  = rem_shift[lpmp_pkg::HDR_NUM_W-1:0];
						nxt_cnt   = '0;
						nxt_inval = 1'b0;
						nxt_phase = (rem_shift[lpmp_pkg::HDR_NUM_W-1:0] != '0)
							? lpmp_pkg::PH_HLEN : lpmp_pkg::PH_BSIZE;
					end
				end
				lpmp_pkg::PH_HLEN: begin
					sec      = inval_q ? lpmp_pkg::SEC_VALUE : lpmp_pkg::SEC_NAME;
					len_byte = 1'b1;
					hnum     = cnt_q;
					nxt_rem  = rem_shift;
					nxt_pos  = pos_inc;
					if (pos_inc == 2'd2) begin
						nxt_pos = '0;
						if (rem_shift != '0) begin
							nxt_phase = lpmp_pkg::PH_HTEXT;
						end else if (!inval_q) begin
							nxt_inval = 1'b1;
							nxt_phase = lpmp_pkg::PH_HLEN;
						end else begin
							nxt_inval = 1'b0;
							nxt_cnt   = cnt_q + 1'b1;
							nxt_left  = left_dec;
							nxt_phase = (left_dec != '0) ? lpmp_pkg::PH_HLEN : lpmp_pkg::PH_BSIZE;
						end
					end
				end
				lpmp_pkg::PH_HTEXT: begin
					sec     = inval_q ? lpmp_pkg::SEC_VALUE : lpmp_pkg::SEC_NAME;
					hnum    = cnt_q;
					nxt_rem = rem_dec;
					if (rem_dec == '0) begin
						if (!inval_q) begin
							nxt_inval = 1'b1;
							nxt_phase = lpmp_pkg::PH_HLEN;
						end else begin
							nxt_inval = 1'b0;
							nxt_cnt   = cnt_q + 1'b1;
							nxt_left  = left_dec;
							nxt_phase = (left_dec != '0) ? lpmp_pkg::PH_HLEN : lpmp_pkg::PH_BSIZE;
						end
					end
				end
				lpmp_pkg::PH_BSIZE: begin
					sec      = lpmp_pkg::SEC_BSIZE;
					len_byte = 1'b1;
					nxt_rem  = rem_shift;
					nxt_pos  = pos_inc;
					// four bytes taken when the position wraps
					if (pos_inc == '0) begin
						nxt_phase = lpmp_pkg::PH_BODY;
					end
				end
				lpmp_pkg::PH_BODY: begin
					if (rem_q == '0) begin
						sec     = lpmp_pkg::SEC_DISCARD;
						nxt_err = lpmp_pkg::ERR_BODY;
					end else begin
						sec     = lpmp_pkg::SEC_BODY;
						nxt_rem = rem_dec;
					end
				end
				default: begin
					sec = lpmp_pkg::SEC_MARKER;
					if (byte_ch.in_byte == (frame_mode_q ? lpmp_pkg::MARK_RESPONSE
							: lpmp_pkg::MARK_REQUEST)) begin
						nxt_phase = frame_mode_q ? lpmp_pkg::PH_STATUS : lpmp_pkg::PH_TLEN;
						nxt_tfn   = '0;
						nxt_pos   = '0;
					end else begin
						nxt_err = lpmp_pkg::ERR_MARKER;
					end
				end
			endcase
		end

		if (byte_ch.last_byte) begin
			if (nxt_err != lpmp_pkg::ERR_NONE) begin
				code = nxt_err;
			end else begin
				case (nxt_phase)
					lpmp_pkg::PH_HCOUNT: code = lpmp_pkg::ERR_HCOUNT;
					lpmp_pkg::PH_HLEN,
					lpmp_pkg::PH_HTEXT:  code = lpmp_pkg::ERR_HEADER;
					lpmp_pkg::PH_BSIZE:  code = lpmp_pkg::ERR_BSIZE;
					lpmp_pkg::PH_BODY:   code = (nxt_rem != '0) ? lpmp_pkg::ERR_BODY
						: lpmp_pkg::ERR_NONE;
					default:             code = lpmp_pkg::ERR_LEADING;
				endcase
			end
			nxt_phase = lpmp_pkg::PH_MARKER;
			nxt_pos   = '0;
			nxt_rem   = '0;
			nxt_tfn   = '0;
			nxt_left  = '0;
			nxt_cnt   = '0;
			nxt_inval = 1'b0;
			nxt_err   = lpmp_pkg::ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lpmp_pkg::PH_MARKER;
			pos_q   <= '0;
			rem_q   <= '0;
			tfn_q   <= '0;
			left_q  <= '0;
			cnt_q   <= '0;
			inval_q <= 1'b0;
			err_q   <= lpmp_pkg::ERR_NONE;
		end else if (in_acc) begin
			phase_q <= nxt_phase;
			pos_q   <= nxt_pos;
			rem_q   <= nxt_rem;
			tfn_q   <= nxt_tfn;
			left_q  <= nxt_left;
			cnt_q   <= nxt_cnt;
			inval_q <= nxt_inval;
			err_q   <= nxt_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (tag_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_byte_q <= byte_ch.in_byte;
			section_q  <= sec;
			len_q      <= len_byte;
			hnum_q     <= hnum;
			done_q     <= byte_ch.last_byte;
			code_q     <= code;
		end
	end

	assign tag_ch.valid          = out_valid_q;
	assign tag_ch.out_byte       = out_byte_q;
	assign tag_ch.section        = section_q;
	assign tag_ch.is_length_byte = len_q;
	assign tag_ch.header_number  = hnum_q;
	assign tag_ch.message_done   = done_q;
	assign tag_ch.error_kind     = code_q;

	a_err_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		tag_ch.valid && (tag_ch.error_kind != lpmp_pkg::ERR_NONE) |-> tag_ch.message_done)
		else $error("error kind reported on a byte that is not the last");

	a_rearm_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && byte_ch.last_byte |=> (phase_q == lpmp_pkg::PH_MARKER)
			&& (err_q == lpmp_pkg::ERR_NONE) && (cnt_q == '0))
		else $error("parser did not re-arm after the last byte");

	a_hnum_in_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		tag_ch.valid && (tag_ch.header_number != '0) |->
			(tag_ch.section == lpmp_pkg::SEC_NAME) || (tag_ch.section == lpmp_pkg::SEC_VALUE))
		else $error("header number outside a name/value section");

	a_len_not_payload: assert property (@(posedge clk) disable iff (!arst_n)
		tag_ch.valid && tag_ch.is_length_byte |->
			(tag_ch.section != lpmp_pkg::SEC_MARKER) && (tag_ch.section != lpmp_pkg::SEC_STATUS)
			&& (tag_ch.section != lpmp_pkg::SEC_BODY) && (tag_ch.section != lpmp_pkg::SEC_DISCARD))
		else $error("length flag on a non-prefix section");

	a_result_follows_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> tag_ch.valid)
		else $error("accepted request produced no result");

endmodule
